// ===== sv/icmp_rc_pkg.sv =====
package icmp_rc_pkg;

  typedef logic [1:0] reply_class_t;

  localparam reply_class_t CLS_OTHER   = 2'd0;
  localparam reply_class_t CLS_EXPIRED = 2'd1;
  localparam reply_class_t CLS_ECHO    = 2'd2;

  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] ICMP_HDR_SKIP      = 8'd8;
  localparam logic [7:0] ID_OFFSET          = 8'd4;
  localparam logic [7:0] POS_MAX            = 8'd255;
  localparam logic [3:0] MIN_IHL            = 4'd5;

  function automatic logic [5:0] hdr_len_of(input logic [7:0] b);
    logic [3:0] ihl;
    ihl = b[3:0];
    return (ihl >= MIN_IHL) ? {ihl, 2'b00} : 6'd0;
  endfunction

endpackage

// ===== sv/icmp_reply_classifier_unit.sv =====
// icmp reply classifier
// in channel: in_pkt_byte / in_last_byte, one byte of a received ipv4
// packet per item, in wire order, under in_valid / in_ready.
// out channel: out_reply_class under out_valid / out_ready, one item per
// packet, issued for the packet's last byte: other, time exceeded quoting
// our probe id, or echo reply carrying our probe id.
// cfg port: cfg_wr_en / cfg_wr_data load the 16-bit probe id; write only
// while no packet is in flight.
// a byte taken is held in the input register and classified from there
// into the output register; out_valid rises there for the packet's last
// byte, unless a pending result stalls that byte in the input register.
// throughput: one byte per cycle unless a last byte waits on a stalled
// result; the single classification pass between the registers sets that figure.
// reset (rst_n low at a clock edge) empties both registers, clears the
// packet state and the probe id to zero.
// when the receiver holds out_ready low with a result pending, a further
// last byte waits in the input register and in_ready drops; other bytes
// keep flowing.
module icmp_reply_classifier_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_pkt_byte,
  input  logic                      in_last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output icmp_rc_pkg::reply_class_t out_reply_class,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data
);

  logic                      s1_valid_r, s1_valid_nxt;
  logic [7:0]                s1_byte_r;
  logic                      s1_last_r;
  logic                      s1_go;

  logic [15:0]               probe_id_r;
  logic [7:0]                byte_pos_r, byte_pos_nxt;
  logic [5:0]                outer_len_r, outer_len_nxt;
  logic [7:0]                icmp_kind_r, icmp_kind_nxt;
  logic [5:0]                inner_len_r, inner_len_nxt;
  logic [7:0]                id_high_r, id_high_nxt;
  icmp_rc_pkg::reply_class_t verdict_r, verdict_nxt;

  logic                      out_valid_r, out_valid_nxt;
  icmp_rc_pkg::reply_class_t out_class_r;

  logic [7:0]                hdr_end;
  logic [7:0]                inner_at;
  logic [7:0]                id_at;
  logic                      id_check;
  icmp_rc_pkg::reply_class_t id_cls;
  icmp_rc_pkg::reply_class_t verdict_upd;

  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  assign hdr_end  = {2'b00, outer_len_r};
  assign inner_at = hdr_end + icmp_rc_pkg::ICMP_HDR_SKIP;

  // field decode for the byte held in the input register
  always_comb begin
    outer_len_nxt = outer_len_r;
    icmp_kind_nxt = icmp_kind_r;
    inner_len_nxt = inner_len_r;
    id_high_nxt   = id_high_r;
    verdict_upd   = verdict_r;
    id_check      = 1'b0;
    id_at         = hdr_end + icmp_rc_pkg::ID_OFFSET;
    id_cls        = icmp_rc_pkg::CLS_ECHO;

    if (byte_pos_r == 8'd0) begin
      outer_len_nxt = icmp_rc_pkg::hdr_len_of(s1_byte_r);
      verdict_upd   = icmp_rc_pkg::CLS_OTHER;
    end else if (outer_len_r != 6'd0) begin
      if (byte_pos_r == hdr_end) begin
        icmp_kind_nxt = s1_byte_r;
      end else if (byte_pos_r > hdr_end) begin
        if (icmp_kind_r == icmp_rc_pkg::TYPE_ECHO_REPLY) begin
          id_check = 1'b1;
        end else if (icmp_kind_r == icmp_rc_pkg::TYPE_TIME_EXCEEDED) begin
          if (byte_pos_r == inner_at) begin
            inner_len_nxt = icmp_rc_pkg::hdr_len_of(s1_byte_r);
          end else if (byte_pos_r > inner_at && inner_len_r != 6'd0) begin
            id_check = 1'b1;
            id_at    = inner_at + {2'b00, inner_len_r} + icmp_rc_pkg::ID_OFFSET;
            id_cls   = icmp_rc_pkg::CLS_EXPIRED;
          end
        end
      end
    end

    if (id_check) begin
      if (byte_pos_r == id_at) begin
        id_high_nxt = s1_byte_r;
      end else if (byte_pos_r == id_at + 8'd1) begin
        verdict_upd = ({id_high_r, s1_byte_r} == probe_id_r) ? id_cls
                                                            : icmp_rc_pkg::CLS_OTHER;
      end
    end
  end

  // packet state advance
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    verdict_nxt  = verdict_r;
    if (s1_go) begin
      verdict_nxt = verdict_upd;
      if (byte_pos_r != icmp_rc_pkg::POS_MAX) begin
        byte_pos_nxt = byte_pos_r + 8'd1;
      end
      if (s1_last_r) begin
        byte_pos_nxt = 8'd0;
        verdict_nxt  = icmp_rc_pkg::CLS_OTHER;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      probe_id_r  <= 16'd0;
      byte_pos_r  <= 8'd0;
      outer_len_r <= 6'd0;
      icmp_kind_r <= 8'd0;
      inner_len_r <= 6'd0;
      id_high_r   <= 8'd0;
      verdict_r   <= icmp_rc_pkg::CLS_OTHER;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      byte_pos_r  <= byte_pos_nxt;
      verdict_r   <= verdict_nxt;
      if (cfg_wr_en) begin
        probe_id_r <= cfg_wr_data;
      end
      if (s1_go) begin
        if (s1_last_r) begin
          outer_len_r <= 6'd0;
          icmp_kind_r <= 8'd0;
          inner_len_r <= 6'd0;
          id_high_r   <= 8'd0;
        end else begin
          outer_len_r <= outer_len_nxt;
          icmp_kind_r <= icmp_kind_nxt;
          inner_len_r <= inner_len_nxt;
          id_high_r   <= id_high_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_pkt_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_go && s1_last_r) begin
      out_class_r <= verdict_upd;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reply_class = out_class_r;

endmodule

// ===== sv/icmp_rc_checker.sv =====
module icmp_rc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last_byte,
  input logic                      out_valid,
  input logic                      out_ready,
  input icmp_rc_pkg::reply_class_t out_reply_class
);

  // reset empties the result register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // a held result keeps its class
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reply_class))
    else $error("stalled result changed");

  a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reply_class == icmp_rc_pkg::CLS_OTHER ||
                   out_reply_class == icmp_rc_pkg::CLS_EXPIRED ||
                   out_reply_class == icmp_rc_pkg::CLS_ECHO))
    else $error("unused class code on output");

  // a fresh result follows a last byte that passed through the input register
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte, 2))
    else $error("result without a last byte");

endmodule

bind icmp_reply_classifier_unit icmp_rc_checker u_icmp_rc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_byte    (in_last_byte),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_reply_class (out_reply_class)
);

// ===== verif/icmp_reply_classifier_unit_tb.sv =====
`timescale 1ns / 100ps

module icmp_reply_classifier_unit_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 8;
  localparam int HOLD_TICKS   = 400;

  typedef enum int {
    SHAPE_ECHO,
    SHAPE_EXPIRED,
    SHAPE_OTHER,
    SHAPE_SHORT_IHL,
    SHAPE_NOISE
  } pkt_shape_t;

  class reply_scoreboard_t;
    logic [15:0]               probe_id;
    int                        byte_pos;
    int                        outer_len;
    int                        inner_len;
    logic [7:0]                icmp_kind;
    logic [7:0]                id_hi;
    icmp_rc_pkg::reply_class_t verdict;
    icmp_rc_pkg::reply_class_t expected_classes[$];
    int                        mismatches;
    int                        bytes_taken;
    int                        packets_taken;
    int                        class_count[3];

    function new();
      probe_id = '0;
      mismatches = 0;
      bytes_taken = 0;
      packets_taken = 0;
      class_count = '{0, 0, 0};
      clear_packet();
    endfunction

    function void clear_packet();
      byte_pos = 0;
      outer_len = 0;
      inner_len = 0;
      icmp_kind = '0;
      id_hi = '0;
      verdict = icmp_rc_pkg::CLS_OTHER;
    endfunction

    function void set_probe_id(logic [15:0] v);
      probe_id = v;
    endfunction

    function int hdr_bytes(logic [7:0] b);
      return (b[3:0] >= icmp_rc_pkg::MIN_IHL) ? int'(b[3:0]) * 4 : 0;
    endfunction

    function void take_id(int pos, int id_at, logic [7:0] b,
                          icmp_rc_pkg::reply_class_t cls);
      if (pos == id_at) begin
        id_hi = b;
      end else if (pos == id_at + 1) begin
        verdict = ({id_hi, b} == probe_id) ? cls : icmp_rc_pkg::CLS_OTHER;
      end
    endfunction

    // predicts the class of the packet from each accepted byte
    function void note_byte(logic [7:0] b, logic last);
      int pos;
      int inner_start;
      pos = byte_pos;
      bytes_taken++;
      if (pos == 0) begin
        outer_len = hdr_bytes(b);
        verdict = icmp_rc_pkg::CLS_OTHER;
      end else if (outer_len != 0) begin
        if (pos == outer_len) begin
          icmp_kind = b;
        end else if (pos > outer_len) begin
          if (icmp_kind == icmp_rc_pkg::TYPE_ECHO_REPLY) begin
            take_id(pos, outer_len + int'(icmp_rc_pkg::ID_OFFSET), b,
                    icmp_rc_pkg::CLS_ECHO);
          end else if (icmp_kind == icmp_rc_pkg::TYPE_TIME_EXCEEDED) begin
            inner_start = outer_len + int'(icmp_rc_pkg::ICMP_HDR_SKIP);
            if (pos == inner_start) begin
              inner_len = hdr_bytes(b);
            end else if (pos > inner_start && inner_len != 0) begin
              take_id(pos, inner_start + inner_len + int'(icmp_rc_pkg::ID_OFFSET), b,
                      icmp_rc_pkg::CLS_EXPIRED);
            end
          end
        end
      end
      if (byte_pos < int'(icmp_rc_pkg::POS_MAX)) byte_pos++;
      if (last) begin
        expected_classes.push_back(verdict);
        packets_taken++;
        clear_packet();
      end
    endfunction

    function void note_mismatch(string what, icmp_rc_pkg::reply_class_t want,
                                icmp_rc_pkg::reply_class_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: reply_class expected %0d got %0d", $realtime, what, want, got);
      end
    endfunction

    function void check_result(icmp_rc_pkg::reply_class_t got);
      icmp_rc_pkg::reply_class_t want;
      if (expected_classes.size() == 0) begin
        note_mismatch("result with no packet pending", 'x, got);
        return;
      end
      want = expected_classes.pop_front();
      if (got !== want) begin
        note_mismatch("wrong class", want, got);
      end else begin
        class_count[want]++;
      end
    endfunction

    function int pending();
      return expected_classes.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_pkt_byte = '0;
  logic                      in_last_byte = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  icmp_rc_pkg::reply_class_t out_reply_class;
  logic                      cfg_wr_en = 1'b0;
  logic [15:0]               cfg_wr_data = '0;

  reply_scoreboard_t sb;
  logic [7:0]  pkt[$];
  logic [15:0] probe_now = '0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          probe_writes = 0;

  icmp_reply_classifier_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pkt_byte     (in_pkt_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reply_class (out_reply_class),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_byte(in_pkt_byte, in_last_byte);
    if (rst_n && out_valid && out_ready) sb.check_result(out_reply_class);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pkt_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drive_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_probe_id(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_probe_id(v);
    probe_now = v;
    probe_writes++;
  endtask

  // cut_len of 0 keeps the whole packet
  task automatic build_packet(input pkt_shape_t shape, input int ihl, input int inner_ihl,
                              input bit id_match, input int cut_len, input int tail);
    int          h;
    int          tpos;
    int          idpos;
    int          len;
    logic [7:0]  kind;
    logic [15:0] id;
    h = ihl * 4;
    tpos = (shape == SHAPE_SHORT_IHL) ? 20 : h;
    id = id_match ? probe_now : probe_now ^ (16'd1 << $urandom_range(15));
    case (shape)
      SHAPE_ECHO, SHAPE_SHORT_IHL: idpos = tpos + icmp_rc_pkg::ID_OFFSET;
      SHAPE_EXPIRED: begin
        idpos = h + icmp_rc_pkg::ICMP_HDR_SKIP + icmp_rc_pkg::ID_OFFSET +
                ((inner_ihl >= icmp_rc_pkg::MIN_IHL) ? inner_ihl * 4 : 20);
      end
      default: idpos = h + $urandom_range(8);
    endcase
    len = (shape == SHAPE_NOISE) ? $urandom_range(60, 1) : idpos + 2 + tail;
    pkt.delete();
    repeat (len) pkt.push_back(8'($urandom));
    if (shape != SHAPE_NOISE) begin
      pkt[0] = {pkt[0][7:4], 4'(ihl)};
      pkt[idpos] = id[15:8];
      pkt[idpos + 1] = id[7:0];
      case (shape)
        SHAPE_ECHO, SHAPE_SHORT_IHL: pkt[tpos] = icmp_rc_pkg::TYPE_ECHO_REPLY;
        SHAPE_EXPIRED: begin
          pkt[tpos] = icmp_rc_pkg::TYPE_TIME_EXCEEDED;
          pkt[h + icmp_rc_pkg::ICMP_HDR_SKIP] =
            {pkt[h + icmp_rc_pkg::ICMP_HDR_SKIP][7:4], 4'(inner_ihl)};
        end
        default: begin
          kind = 8'($urandom);
          while (kind == icmp_rc_pkg::TYPE_ECHO_REPLY ||
                 kind == icmp_rc_pkg::TYPE_TIME_EXCEEDED) kind = 8'($urandom);
          pkt[tpos] = kind;
        end
      endcase
    end
    if (cut_len > 0) begin
      while (pkt.size() > cut_len) void'(pkt.pop_back());
    end
  endtask

  task automatic random_packet(input int max_tail);
    int         roll;
    pkt_shape_t shape;
    int         ihl;
    int         inner_ihl;
    int         tail;
    int         cut_len;
    roll = $urandom_range(99);
    if (roll < 30) shape = SHAPE_ECHO;
    else if (roll < 60) shape = SHAPE_EXPIRED;
    else if (roll < 70) shape = SHAPE_OTHER;
    else if (roll < 78) shape = SHAPE_SHORT_IHL;
    else shape = SHAPE_NOISE;
    if (shape == SHAPE_SHORT_IHL) ihl = $urandom_range(4);
    else ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
    if ($urandom_range(9) == 0) inner_ihl = $urandom_range(4);
    else inner_ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
    if (max_tail > 8 && $urandom_range(49) == 0) tail = $urandom_range(max_tail, 230);
    else tail = $urandom_range(8);
    cut_len = ($urandom_range(6) == 0) ? $urandom_range(90, 1) : 0;
    build_packet(shape, ihl, inner_ihl, $urandom_range(1), cut_len, tail);
  endtask

  task automatic random_traffic(input int n_bytes, input int n_pkts);
    int sent;
    int pkts;
    sent = 0;
    pkts = 0;
    while (sent < n_bytes || pkts < n_pkts) begin
      random_packet(300);
      drive_packet();
      sent += pkt.size();
      pkts++;
      // occasional full pause until the block is empty
      if ($urandom_range(24) == 0) drain_results();
    end
  endtask

  initial begin
    logic [15:0] phase_probe[4];
    int          idle_pct[4];
    int          stall_pct[4];
    sb = new();
    phase_probe = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h8001};
    idle_pct = '{0, 45, 0, 17};
    stall_pct = '{0, 0, 45, 17};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset probe id of zero, then a one-byte packet
    build_packet(SHAPE_ECHO, 5, 5, 1'b1, 0, 0);
    drive_packet();
    pkt.delete();
    pkt.push_back(8'hFF);
    drive_packet();
    drain_results();

    write_probe_id(16'hA5C3);
    build_packet(SHAPE_ECHO, 15, 5, 1'b1, 0, 2);
    drive_packet();
    build_packet(SHAPE_ECHO, 5, 5, 1'b0, 0, 0);
    drive_packet();
    build_packet(SHAPE_EXPIRED, 5, 5, 1'b1, 0, 0);
    drive_packet();
    build_packet(SHAPE_EXPIRED, 15, 15, 1'b1, 0, 1);
    drive_packet();
    build_packet(SHAPE_EXPIRED, 5, 4, 1'b1, 0, 0);
    drive_packet();
    build_packet(SHAPE_SHORT_IHL, 4, 5, 1'b1, 0, 0);
    drive_packet();
    build_packet(SHAPE_OTHER, 5, 5, 1'b1, 0, 3);
    drive_packet();
    // ends with the id low byte missing
    build_packet(SHAPE_ECHO, 5, 5, 1'b1, 25, 0);
    drive_packet();
    build_packet(SHAPE_EXPIRED, 6, 5, 1'b1, 57, 4);
    drive_packet();
    // past the saturating byte position
    build_packet(SHAPE_ECHO, 5, 5, 1'b1, 0, 280);
    drive_packet();
    pkt.delete();
    repeat (30) pkt.push_back(8'h00);
    drive_packet();
    drain_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      write_probe_id(phase_probe[p]);
      random_traffic(180, 6);
      drain_results();
    end

    // receiver held off while short packets keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_probe_id(16'($urandom));
    hold_left = HOLD_TICKS;
    for (int n = 0; n < 25; n++) begin
      if ($urandom_range(3) == 0) begin
        pkt.delete();
        repeat ($urandom_range(3, 1)) pkt.push_back(8'($urandom));
      end else begin
        build_packet(SHAPE_ECHO, 5, 5, $urandom_range(1), 0, 0);
      end
      drive_packet();
    end
    drain_results();

    sb.mismatches += sb.pending();
    $display("%0d bytes in %0d packets, %0d probe id writes, four idle mixes and a long hold",
             sb.bytes_taken, sb.packets_taken, probe_writes);
    $display("matched classes other/expired/echo: %0d/%0d/%0d, mismatches: %0d",
             sb.class_count[0], sb.class_count[1], sb.class_count[2], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== icmp_reply_classifier_unit.f =====
sv/icmp_rc_pkg.sv
sv/icmp_reply_classifier_unit.sv
sv/icmp_rc_checker.sv
verif/icmp_reply_classifier_unit_tb.sv
